>>> src/kvt_pkg.sv
// Shared types and constants of the key/value property tokenizer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package kvt_pkg;

  // Field widths of a request and a result
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned OFFSET_W  = 12;
  localparam int unsigned LENGTH_W  = 13;
  localparam int unsigned DCOUNT_W  = 3;
  localparam int unsigned NUM_DELIM = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Separator between key and value
  localparam logic [CHAR_W-1:0] EQ_BYTE = 8'h3D;

  // Register reset values
  localparam logic [DCOUNT_W-1:0] DCOUNT_RESET  = 3'd1;
  localparam logic [CHAR_W-1:0]   DELIM_A_RESET = 8'h0A;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELIM_COUNT = 3'd0,
    CFG_DELIM_A     = 3'd1,
    CFG_DELIM_B     = 3'd2,
    CFG_DELIM_C     = 3'd3,
    CFG_DELIM_D     = 3'd4
  } cfg_reg_t;

  // Scanner phase within a segment
  typedef enum logic [2:0] {
    PH_BETWEEN = 3'd0,
    PH_LEAD    = 3'd1,
    PH_KEY     = 3'd2,
    PH_VLEAD   = 3'd3,
    PH_VALUE   = 3'd4,
    PH_DISCARD = 3'd5
  } phase_t;

  typedef logic [NUM_DELIM-1:0][CHAR_W-1:0] delim_bytes_t;

  // Classification of one byte
  typedef struct packed {
    logic is_delim;
    logic is_ws;
    logic is_eq;
  } byte_class_t;

  // One result
  typedef struct packed {
    logic [OFFSET_W-1:0] key_offset;
    logic [LENGTH_W-1:0] key_length;
    logic                value_present;
    logic [OFFSET_W-1:0] value_offset;
    logic [LENGTH_W-1:0] value_length;
    logic                overflow;
  } token_t;

endpackage
`default_nettype wire

>>> src/kvt_ifs.sv
// Valid/ready channel interfaces: bytes into the tokenizer, tokens out of it.
// Depends on kvt_pkg for field widths.
`default_nettype none
interface kvt_char_if;
  import kvt_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;
  logic              final_byte;

  modport source (output valid, output char_byte, output final_byte, input ready);
  modport sink   (input valid, input char_byte, input final_byte, output ready);
endinterface

interface kvt_token_if;
  import kvt_pkg::*;
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] key_offset;
  logic [LENGTH_W-1:0] key_length;
  logic                value_present;
  logic [OFFSET_W-1:0] value_offset;
  logic [LENGTH_W-1:0] value_length;
  logic                overflow;

  modport source (output valid, output key_offset, output key_length,
                  output value_present, output value_offset, output value_length,
                  output overflow, input ready);
  modport sink   (input valid, input key_offset, input key_length,
                  input value_present, input value_offset, input value_length,
                  input overflow, output ready);
endinterface
`default_nettype wire

>>> src/kvt_byte_class.sv
// Byte classifier: delimiter match against the enabled registers,
// C-locale whitespace and the '=' separator. Depends on kvt_pkg.
`default_nettype none
module kvt_byte_class (
  input  logic [kvt_pkg::CHAR_W-1:0]   char_byte,
  input  logic [kvt_pkg::DCOUNT_W-1:0] delim_count,
  input  kvt_pkg::delim_bytes_t        delim_bytes,
  output kvt_pkg::byte_class_t         cls
);
  import kvt_pkg::*;

  logic [NUM_DELIM-1:0] hit;

  // Match each delimiter register; a count of four or more enables all of them
  always_comb begin
    for (int i = 0; i < NUM_DELIM; i++) begin
      hit[i] = (delim_count > DCOUNT_W'(i)) && (delim_bytes[i] == char_byte);
    end
  end

  assign cls.is_delim = |hit;
  assign cls.is_ws    = (char_byte == 8'h20) || ((char_byte >= 8'h09) && (char_byte <= 8'h0D));
  assign cls.is_eq    = (char_byte == EQ_BYTE);

endmodule
`default_nettype wire

>>> src/kvt_segment.sv
// Segment scanner: running position and phase, key/value bounds, and the
// token formed when a segment closes. Depends on kvt_pkg.
`default_nettype none
module kvt_segment #(
  parameter int unsigned MAX_STRING_LENGTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 last,
  input  kvt_pkg::byte_class_t cls,
  output logic                 emit,
  output kvt_pkg::token_t      token
);
  import kvt_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_STRING_LENGTH + 1);

  logic [POS_W-1:0] pos, pos_next;
  logic             sat, sat_mid;
  phase_t           phase, phase_mid, phase_next;
  logic [POS_W-1:0] key_begin, key_end, value_begin, value_end;
  logic [POS_W-1:0] kb_mid, ke_mid, vb_mid, ve_mid;
  logic [POS_W-1:0] beg, endp;

  // Advance the position, saturating at capacity
  always_comb begin
    pos_next = pos;
    sat_mid  = sat;
    beg      = pos;
    endp     = pos + 1'b1;
    if (pos >= POS_W'(MAX_STRING_LENGTH)) begin
      sat_mid = 1'b1;
      beg     = POS_W'(MAX_STRING_LENGTH - 1);
      endp    = POS_W'(MAX_STRING_LENGTH);
    end else begin
      pos_next = pos + 1'b1;
    end
  end

  // Update phase and bounds for a non-delimiter byte
  always_comb begin
    phase_mid = phase;
    kb_mid    = key_begin;
    ke_mid    = key_end;
    vb_mid    = value_begin;
    ve_mid    = value_end;
    if (!cls.is_delim) begin
      if (phase_mid == PH_BETWEEN) phase_mid = PH_LEAD;
      case (phase_mid)
        PH_LEAD: begin
          if (cls.is_eq) begin
            phase_mid = PH_DISCARD;
          end else if (!cls.is_ws) begin
            kb_mid    = beg;
            ke_mid    = endp;
            phase_mid = PH_KEY;
          end
        end
        PH_KEY: begin
          if (cls.is_eq) phase_mid = PH_VLEAD;
          else if (!cls.is_ws) ke_mid = endp;
        end
        PH_VLEAD: begin
          if (!cls.is_ws) begin
            vb_mid    = beg;
            ve_mid    = endp;
            phase_mid = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (!cls.is_ws) ve_mid = endp;
        end
        default: ;
      endcase
    end
  end

  // Next phase: a delimiter closes the segment
  always_comb begin
    phase_next = cls.is_delim ? PH_BETWEEN : phase_mid;
  end

  // Form the token on segment close
  always_comb begin
    emit                = (cls.is_delim || last) &&
                          ((phase_mid == PH_KEY) || (phase_mid == PH_VALUE));
    token.key_offset    = OFFSET_W'(kb_mid);
    token.key_length    = LENGTH_W'(ke_mid - kb_mid);
    token.overflow      = sat_mid;
    token.value_present = 1'b0;
    token.value_offset  = '0;
    token.value_length  = '0;
    if (phase_mid == PH_VALUE) begin
      token.value_present = 1'b1;
      token.value_offset  = OFFSET_W'(vb_mid);
      token.value_length  = LENGTH_W'(ve_mid - vb_mid);
    end
  end

  // Hold state between requests; restart after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      sat         <= 1'b0;
      phase       <= PH_BETWEEN;
      key_begin   <= '0;
      key_end     <= '0;
      value_begin <= '0;
      value_end   <= '0;
    end else if (step) begin
      if (last) begin
        pos         <= '0;
        sat         <= 1'b0;
        phase       <= PH_BETWEEN;
        key_begin   <= '0;
        key_end     <= '0;
        value_begin <= '0;
        value_end   <= '0;
      end else begin
        pos         <= pos_next;
        sat         <= sat_mid;
        phase       <= phase_next;
        key_begin   <= kb_mid;
        key_end     <= ke_mid;
        value_begin <= vb_mid;
        value_end   <= ve_mid;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/kvt_out_stage.sv
// Result register between the scanner and the token channel; decouples
// acceptance of the next byte from a stalled receiver. Depends on kvt_pkg.
`default_nettype none
module kvt_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic            load_valid,
  input  kvt_pkg::token_t load_token,
  output logic            can_load,
  output logic            valid,
  input  logic            ready,
  output kvt_pkg::token_t token
);
  import kvt_pkg::*;

  assign can_load = !valid || ready;

  // Hold the token until taken; refill on every accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= load_valid;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      token <= load_token;
    end
  end

endmodule
`default_nettype wire

>>> src/key_value_property_tokenizer.sv
// Key/value property tokenizer, top level.
// Bytes of a property string arrive on the chars channel (valid/ready), with
// final_byte set on the last byte of each string. Runs of the configured
// delimiter bytes split the string into segments; each closing segment that
// holds a non-empty key yields one token on the tokens channel: key offset
// and length, and value offset and length when a non-empty value follows '='.
// Delimiters are set through cfg_we/cfg_index/cfg_data while the block is idle;
// the user must keep to this, as the block does not enforce it. Throughput: one
// byte per cycle; chars.ready stays high while the result register is empty or
// being taken; when the receiver stalls with a token pending, chars.ready drops
// and input waits. Classification and the segment update are one combinational
// pass between the scanner state and the result register, so a token appears
// on tokens in the cycle after its closing byte. Positions saturate at
// MAX_STRING_LENGTH and set overflow. Reset (rst, synchronous) clears the
// scanner to the start of a string, empties the result register and restores
// delimiter count 1, delimiter LF. State also restarts after every final byte.
`default_nettype none
module key_value_property_tokenizer #(
  parameter int unsigned MAX_STRING_LENGTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [kvt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kvt_pkg::CFG_DATA_W-1:0] cfg_data,
  kvt_char_if.sink                       chars,
  kvt_token_if.source                    tokens
);
  import kvt_pkg::*;

  logic [DCOUNT_W-1:0] delim_count;
  delim_bytes_t        delim_bytes;
  byte_class_t         cls;
  logic                step, emit, can_load;
  token_t              seg_token, out_token;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delim_count    <= DCOUNT_RESET;
      delim_bytes[0] <= DELIM_A_RESET;
      delim_bytes[1] <= '0;
      delim_bytes[2] <= '0;
      delim_bytes[3] <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DELIM_COUNT: delim_count    <= cfg_data[DCOUNT_W-1:0];
        CFG_DELIM_A:     delim_bytes[0] <= cfg_data;
        CFG_DELIM_B:     delim_bytes[1] <= cfg_data;
        CFG_DELIM_C:     delim_bytes[2] <= cfg_data;
        CFG_DELIM_D:     delim_bytes[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept a request whenever the result register can take its outcome
  assign chars.ready = can_load;
  assign step        = chars.valid && can_load;

  kvt_byte_class u_class (
    .char_byte   (chars.char_byte),
    .delim_count (delim_count),
    .delim_bytes (delim_bytes),
    .cls         (cls)
  );

  kvt_segment #(
    .MAX_STRING_LENGTH (MAX_STRING_LENGTH)
  ) u_segment (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .last  (chars.final_byte),
    .cls   (cls),
    .emit  (emit),
    .token (seg_token)
  );

  kvt_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (step),
    .load_valid (emit),
    .load_token (seg_token),
    .can_load   (can_load),
    .valid      (tokens.valid),
    .ready      (tokens.ready),
    .token      (out_token)
  );

  // Drive the token channel payload
  assign tokens.key_offset    = out_token.key_offset;
  assign tokens.key_length    = out_token.key_length;
  assign tokens.value_present = out_token.value_present;
  assign tokens.value_offset  = out_token.value_offset;
  assign tokens.value_length  = out_token.value_length;
  assign tokens.overflow      = out_token.overflow;

endmodule
`default_nettype wire
